@@ design/cpd_pkg.sv @@
package cpd_pkg;

  // Sizes of the payload store and of the result fields.
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 7;
  localparam int unsigned IdxW       = 6;

  localparam logic [ByteW-1:0] SyncReset = 8'hAA;

  // Framing phases of the receiver.
  typedef enum logic [2:0] {
    PhHunt,
    PhCmd,
    PhLen,
    PhData,
    PhCheck,
    PhEmit
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sync;
    logic load_command;
    logic load_length;
    logic load_data;
    logic emitting;
    logic emit_step;
  } cpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync_match;
    logic length_zero;
    logic data_done;
    logic check_ok;
    logic last_result;
  } cpd_status_t;

endpackage

@@ design/cpd_in_if.sv @@
interface cpd_in_if;
  logic                    valid;
  logic                    ready;
  logic [cpd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/cpd_out_if.sv @@
interface cpd_out_if;
  logic                      valid;
  logic                      ready;
  logic [cpd_pkg::ByteW-1:0] command;
  logic [cpd_pkg::LenW-1:0]  length;
  logic [cpd_pkg::IdxW-1:0]  byte_index;
  logic [cpd_pkg::ByteW-1:0] payload_byte;
  logic                      has_data;
  logic                      last;

  modport source (output valid, output command, output length, output byte_index,
                  output payload_byte, output has_data, output last, input ready);
  modport sink (input valid, input command, input length, input byte_index,
                input payload_byte, input has_data, input last, output ready);
endinterface

@@ design/cpd_ctrl.sv @@
module cpd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cpd_pkg::cpd_status_t status_i,
  output cpd_pkg::cpd_cmd_t    cmd_o
);

  cpd_pkg::phase_e state_q, state_d;
  logic            in_take;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpd_pkg::PhHunt;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_take = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      cpd_pkg::PhHunt: begin
        if (in_take && status_i.sync_match) begin
          cmd_o.load_sync = 1'b1;
          state_d         = cpd_pkg::PhCmd;
        end
      end
      cpd_pkg::PhCmd: begin
        if (in_take) begin
          cmd_o.load_command = 1'b1;
          state_d            = cpd_pkg::PhLen;
        end
      end
      cpd_pkg::PhLen: begin
        if (in_take) begin
          cmd_o.load_length = 1'b1;
          state_d = status_i.length_zero ? cpd_pkg::PhCheck : cpd_pkg::PhData;
        end
      end
      cpd_pkg::PhData: begin
        if (in_take) begin
          cmd_o.load_data = 1'b1;
          if (status_i.data_done) begin
            state_d = cpd_pkg::PhCheck;
          end
        end
      end
      cpd_pkg::PhCheck: begin
        if (in_take) begin
          state_d = status_i.check_ok ? cpd_pkg::PhEmit : cpd_pkg::PhHunt;
        end
      end
      cpd_pkg::PhEmit: begin
        in_ready_o     = 1'b0;
        out_valid_o    = 1'b1;
        cmd_o.emitting = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.last_result) begin
            state_d = cpd_pkg::PhHunt;
          end
        end
      end
      default: begin
        state_d = cpd_pkg::PhHunt;
      end
    endcase
  end

endmodule

@@ design/cpd_datapath.sv @@
module cpd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sync_we_i,
  input  logic [cpd_pkg::ByteW-1:0]   sync_data_i,
  input  logic [cpd_pkg::ByteW-1:0]   rx_byte_i,
  input  cpd_pkg::cpd_cmd_t           cmd_i,
  output cpd_pkg::cpd_status_t        status_o,
  output logic [cpd_pkg::ByteW-1:0]   command_o,
  output logic [cpd_pkg::LenW-1:0]    length_o,
  output logic [cpd_pkg::IdxW-1:0]    byte_index_o,
  output logic [cpd_pkg::ByteW-1:0]   payload_byte_o,
  output logic                        has_data_o,
  output logic                        last_o
);

  logic [cpd_pkg::ByteW-1:0] sync_q;
  logic [cpd_pkg::ByteW-1:0] command_q;
  logic [cpd_pkg::ByteW-1:0] length_q;
  logic [cpd_pkg::ByteW-1:0] fill_q, fill_d;
  logic [cpd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [cpd_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [cpd_pkg::AddrW-1:0] rd_addr;
  logic [cpd_pkg::ByteW-1:0] rd_q;
  logic [cpd_pkg::ByteW-1:0] mem [cpd_pkg::MaxPayload];
  logic                      fill_in_range;

  function automatic logic [cpd_pkg::AddrW-1:0] AddrWCast(input logic [cpd_pkg::IdxW-1:0] v);
    return v[cpd_pkg::AddrW-1:0];
  endfunction

  // Sync byte register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= cpd_pkg::SyncReset;
    end else if (sync_we_i) begin
      sync_q <= sync_data_i;
    end
  end

  // Running checksum and fill count.
  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    if (cmd_i.load_sync) begin
      sum_d = rx_byte_i;
    end else if (cmd_i.load_command || cmd_i.load_length || cmd_i.load_data) begin
      sum_d = sum_q + rx_byte_i;
    end
    if (cmd_i.load_length) begin
      fill_d = '0;
    end else if (cmd_i.load_data) begin
      fill_d = fill_q + 8'd1;
    end
  end

  // Emission index: advances per delivered result, rests at zero otherwise.
  always_comb begin
    idx_d = idx_q;
    if (!cmd_i.emitting) begin
      idx_d = '0;
    end else if (cmd_i.emit_step) begin
      idx_d = idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      fill_q    <= '0;
      command_q <= '0;
      length_q  <= '0;
      idx_q     <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      idx_q  <= idx_d;
      if (cmd_i.load_command) begin
        command_q <= rx_byte_i;
      end
      if (cmd_i.load_length) begin
        length_q <= rx_byte_i;
      end
    end
  end

  // Payload store: written while filling, read ahead of the emission index.
  assign fill_in_range = fill_q < 8'(cpd_pkg::MaxPayload);
  assign rd_addr       = cmd_i.emit_step ? AddrWCast(idx_q + 6'd1) : AddrWCast(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_data && fill_in_range) begin
      mem[fill_q[cpd_pkg::AddrW-1:0]] <= rx_byte_i;
    end
    rd_q <= mem[rd_addr];
  end

  // Status for the controller.
  assign status_o.sync_match  = rx_byte_i == sync_q;
  assign status_o.length_zero = rx_byte_i == '0;
  assign status_o.data_done   = {1'b0, fill_q} + 9'd1 >= {1'b0, length_q};
  assign status_o.check_ok    = (sum_q == rx_byte_i) &&
                                (length_q <= 8'(cpd_pkg::MaxPayload));
  assign status_o.last_result = (length_q == '0) ||
                                ({2'b00, idx_q} + 8'd1 == length_q);

  // Result fields.
  assign command_o      = command_q;
  assign length_o       = length_q[cpd_pkg::LenW-1:0];
  assign byte_index_o   = idx_q;
  assign has_data_o     = length_q != '0;
  assign payload_byte_o = has_data_o ? rd_q : '0;
  assign last_o         = status_o.last_result;

endmodule

@@ design/checksummed_packet_deframer.sv @@
// A packet's first result appears in the cycle after its checksum byte is taken.
// Throughput: one received byte per cycle while framing; then one result per cycle, while the sink
// is ready, for the payload burst, during which no byte is taken (the payload store has one read port).
// Reset: asynchronous, active low; returns to sync hunting with the sync byte at 0xAA.
// The payload store is not cleared; only bytes written in the current packet are read.
module checksummed_packet_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sync_byte_we_i,
  input  logic [cpd_pkg::ByteW-1:0] sync_byte_i,
  cpd_in_if.sink                    rx_i,
  cpd_out_if.source                 res_o
);

  cpd_pkg::cpd_cmd_t    cmd;
  cpd_pkg::cpd_status_t status;

  // Framing controller.
  cpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Checksum, payload store and result fields.
  cpd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sync_we_i      (sync_byte_we_i),
    .sync_data_i    (sync_byte_i),
    .rx_byte_i      (rx_i.rx_byte),
    .cmd_i          (cmd),
    .status_o       (status),
    .command_o      (res_o.command),
    .length_o       (res_o.length),
    .byte_index_o   (res_o.byte_index),
    .payload_byte_o (res_o.payload_byte),
    .has_data_o     (res_o.has_data),
    .last_o         (res_o.last)
  );

endmodule
